// ----- rtl/buffer_pool_frame_table_assert.svh -----
// assertion macros for the frame table checker
`ifndef BUFFER_POOL_FRAME_TABLE_ASSERT_SVH
`define BUFFER_POOL_FRAME_TABLE_ASSERT_SVH

`define BPFT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define BPFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bpft_pkg.sv -----
// shared types and constants of the frame table
package bpft_pkg;

    localparam int FRAMES_DEF     = 16;
    localparam int TAG_BITS_DEF   = 32;
    localparam int STAMP_BITS_DEF = 32;
    localparam int PIN_BITS       = 16;
    localparam int ID_BITS        = 32;
    localparam int FI_BITS        = 4;

    typedef enum logic [1:0] {
        FUNC_FETCH = 2'd0,
        FUNC_MARK  = 2'd1,
        FUNC_WB    = 2'd2,
        FUNC_ALLOC = 2'd3
    } t_func;

    typedef struct packed {
        t_func               func;
        logic [ID_BITS-1:0]  page_id;
        logic [FI_BITS-1:0]  frame_index;
    } t_in;

    typedef struct packed {
        logic                status;
        logic                hit;
        logic [FI_BITS-1:0]  frame_out;
        logic                victim_valid;
        logic [ID_BITS-1:0]  victim_page_id;
        logic                writeback_needed;
        logic                new_page_needed;
    } t_out;

endpackage

// ----- rtl/bpft_mem.sv -----
// frame entry memory with registered read and per-entry written flags
module bpft_mem #(
    parameter int DEPTH = bpft_pkg::FRAMES_DEF,
    parameter int WIDTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_wr;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_wr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd_wr <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_wr[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_wr <= r_wr[i_rd_addr];
            end
        end
    end

    // unwritten entries read as the reset value
    assign o_rd_data = r_rd_wr ? r_rd_data : '0;

endmodule

// ----- rtl/buffer_pool_frame_table.sv -----
// frame table of a buffer pool: oldest-first replacement with pin counts
//
// input channel: i_in_valid / o_in_stall carry one operation (fetch,
// mark dirty, write back, allocate view) per transaction
// output channel: o_out_valid / i_out_stall carry one result per operation
// fetch and allocate walk the entry memory one frame a cycle through its
// single read port, then pick a hit, a free frame or a victim; mark dirty
// and write back read, modify and write the one named entry
// one operation is in flight at a time; o_in_stall is high from acceptance
// until the result moves into the output register
// a finished result waits in the output register while i_out_stall is high;
// the next operation is accepted meanwhile but its result waits behind it
// reset clears all frames to free, stamps and pins to zero, tick to zero;
// no clearing pass is needed, the block accepts right after reset
module buffer_pool_frame_table #(
    parameter int FRAMES     = bpft_pkg::FRAMES_DEF,
    parameter int TAG_BITS   = bpft_pkg::TAG_BITS_DEF,
    parameter int STAMP_BITS = bpft_pkg::STAMP_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  bpft_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output bpft_pkg::t_out o_out_data
);

    localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CW = $clog2(FRAMES + 1);
    localparam int PW = bpft_pkg::PIN_BITS;
    localparam int EW = 3 + PW + STAMP_BITS + TAG_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RMW,
        S_DEC,
        S_FIN
    } t_state;

    t_state          r_state;
    bpft_pkg::t_in   r_op;
    bpft_pkg::t_out  r_res;
    bpft_pkg::t_out  r_out;
    logic            r_ovld;
    logic [CW-1:0]   r_cnt;
    logic            r_dv;
    logic [AW-1:0]   r_didx;
    logic [STAMP_BITS-1:0] r_tick;

    logic            r_hit;
    logic [AW-1:0]   r_hidx;
    logic            r_free;
    logic [AW-1:0]   r_fidx;
    logic [PW-1:0]   r_fpins;
    logic            r_best;
    logic [AW-1:0]   r_bidx;
    logic [STAMP_BITS-1:0] r_bstamp;
    logic [TAG_BITS-1:0]   r_btag;
    logic            r_bdirty;
    logic            r_bview;

    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [EW-1:0]   rd_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [EW-1:0]   wr_data;

    logic            e_valid;
    logic            e_view;
    logic            e_dirty;
    logic [PW-1:0]   e_pins;
    logic [STAMP_BITS-1:0] e_stamp;
    logic [TAG_BITS-1:0]   e_tag;

    logic            acc;
    logic            is_alloc;
    logic            fi_ok;
    logic            claim;
    logic [TAG_BITS-1:0] id_tag;
    bpft_pkg::t_out  dec_res;
    bpft_pkg::t_out  rmw_res;
    logic [PW-1:0]   rmw_pins;

    assign acc      = i_in_valid && !o_in_stall;
    assign is_alloc = (r_op.func == bpft_pkg::FUNC_ALLOC);
    assign fi_ok    = int'(r_op.frame_index) < FRAMES;
    assign id_tag   = TAG_BITS'(r_op.page_id);

    assign {e_valid, e_view, e_dirty, e_pins, e_stamp, e_tag} = rd_data;

    bpft_mem #(
        .DEPTH (FRAMES),
        .WIDTH (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    always_comb begin
        rmw_pins = e_pins;
        if (r_op.func == bpft_pkg::FUNC_WB && e_pins != '0) begin
            rmw_pins = e_pins - 1'b1;
        end
        rmw_res           = '0;
        rmw_res.frame_out = r_op.frame_index;
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        claim   = 1'b0;
        dec_res = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc && (i_in_data.func == bpft_pkg::FUNC_MARK ||
                            i_in_data.func == bpft_pkg::FUNC_WB)) begin
                    rd_en   = 1'b1;
                    rd_addr = AW'(i_in_data.frame_index);
                end
            end
            S_SCAN: begin
                if (r_cnt < CW'(FRAMES)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_cnt[AW-1:0];
                end
            end
            S_RMW: begin
                wr_en   = fi_ok;
                wr_addr = AW'(r_op.frame_index);
                wr_data = {e_valid, e_view, (r_op.func == bpft_pkg::FUNC_MARK),
                           rmw_pins, e_stamp, e_tag};
            end
            S_DEC: begin
                priority if (!is_alloc && r_hit) begin
                    dec_res.hit       = 1'b1;
                    dec_res.frame_out = bpft_pkg::FI_BITS'(r_hidx);
                end else if (r_free) begin
                    claim   = 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = r_fidx;
                    wr_data = {1'b1, is_alloc, 1'b0,
                               (is_alloc || r_fpins == '1) ? r_fpins : r_fpins + 1'b1,
                               r_tick, id_tag};
                    dec_res.frame_out = bpft_pkg::FI_BITS'(r_fidx);
                end else if (r_best) begin
                    claim   = 1'b1;
                    wr_en   = 1'b1;
                    wr_addr = r_bidx;
                    wr_data = {1'b1, is_alloc, 1'b0, PW'(1), r_tick, id_tag};
                    dec_res.frame_out        = bpft_pkg::FI_BITS'(r_bidx);
                    dec_res.victim_valid     = 1'b1;
                    dec_res.victim_page_id   = bpft_pkg::ID_BITS'(r_btag);
                    dec_res.writeback_needed = r_bdirty;
                    dec_res.new_page_needed  = r_bdirty && r_bview;
                end else begin
                    dec_res.status = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_dv    <= 1'b0;
            r_tick  <= '0;
            r_hit   <= 1'b0;
            r_free  <= 1'b0;
            r_best  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_dv   <= (r_state == S_SCAN) && rd_en;
            r_didx <= rd_addr;
            if (r_ovld && !i_out_stall && r_state != S_FIN) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_op   <= i_in_data;
                        r_cnt  <= '0;
                        r_hit  <= 1'b0;
                        r_free <= 1'b0;
                        r_best <= 1'b0;
                        if (i_in_data.func == bpft_pkg::FUNC_FETCH ||
                            i_in_data.func == bpft_pkg::FUNC_ALLOC) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_RMW;
                        end
                    end
                end
                S_SCAN: begin
                    if (rd_en) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_dv) begin
                        if (!r_hit && e_valid && !e_view && e_tag == id_tag) begin
                            r_hit  <= 1'b1;
                            r_hidx <= r_didx;
                        end
                        if (!r_free && !e_valid) begin
                            r_free  <= 1'b1;
                            r_fidx  <= r_didx;
                            r_fpins <= e_pins;
                        end
                        if (e_valid && e_pins == '0 && (!r_best || e_stamp < r_bstamp)) begin
                            r_best   <= 1'b1;
                            r_bidx   <= r_didx;
                            r_bstamp <= e_stamp;
                            r_btag   <= e_tag;
                            r_bdirty <= e_dirty;
                            r_bview  <= e_view;
                        end
                        if (r_didx == AW'(FRAMES - 1)) begin
                            r_state <= S_DEC;
                        end
                    end
                end
                S_RMW: begin
                    r_res   <= rmw_res;
                    r_state <= S_FIN;
                end
                S_DEC: begin
                    r_res <= dec_res;
                    if (claim) begin
                        r_tick <= r_tick + 1'b1;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ovld || !i_out_stall) begin
                        r_ovld  <= 1'b1;
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

endmodule

// ----- rtl/bpft_checker.sv -----
// port checker of the frame table and its bind
`include "buffer_pool_frame_table_assert.svh"

module bpft_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input bpft_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input bpft_pkg::t_out o_out_data
);

    `BPFT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled result changed")
    `BPFT_ASSERT_NEXT(a_one_in_flight, i_in_valid && !o_in_stall, o_in_stall, "second transaction accepted while busy")
    `BPFT_ASSERT_IMPL(a_fail_clean, o_out_valid && o_out_data.status, !o_out_data.hit && !o_out_data.victim_valid && o_out_data.frame_out == '0, "failed claim carries data")
    `BPFT_ASSERT_IMPL(a_victim_fields, o_out_valid && (o_out_data.hit || !o_out_data.victim_valid), o_out_data.victim_page_id == '0 && !o_out_data.writeback_needed && !o_out_data.new_page_needed, "victim fields without eviction")
    `BPFT_ASSERT_IMPL(a_view_dirty, o_out_valid && o_out_data.new_page_needed, o_out_data.writeback_needed && o_out_data.victim_valid, "new page without dirty victim")

endmodule

bind buffer_pool_frame_table bpft_checker u_bpft_checker (.*);
